// ----- rtl/r2h_pkg.sv -----
// Shared constants and types for the RGB to HSV pixel converter.
package r2h_pkg;

   // Hue is unsigned Q9.6 degrees: 64 codes per degree, 23040 codes per circle.
   localparam int HUE_BITS = 15;
   localparam int HUE_Q_BITS = 12;

   localparam logic [HUE_Q_BITS-1:0] HUE_SIXTH = 12'd3840;
   localparam logic [HUE_BITS-1:0] HUE_THIRD = 15'd7680;
   localparam logic [HUE_BITS-1:0] HUE_TWO_THIRDS = 15'd15360;
   localparam logic [HUE_BITS-1:0] HUE_FULL = 15'd23040;

   // Which channel holds the maximum, after tie breaking.
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

endpackage

// ----- rtl/rgb_to_hsv_pixel_convert_core.sv -----
// Pipelined RGB to HSV pixel converter with a two-entry output buffer.
// DIV_BITS = max(CHANNEL_BITS, 12), with one quotient bit per divider stage.
// Throughput: one beat per cycle unless the output buffer is full (req_stall high);
// both long dividers are unrolled into stages.
// Reset clears all valid bits and the output buffer; payload registers are not reset.
// req_stall is a registered flag: it rises only when the output buffer holds two beats.
module rgb_to_hsv_pixel_convert_core #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [CHANNEL_BITS-1:0] req_red,
   input  logic [CHANNEL_BITS-1:0] req_green,
   input  logic [CHANNEL_BITS-1:0] req_blue,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [14:0]             rsp_hue,
   output logic [CHANNEL_BITS-1:0] rsp_saturation,
   output logic [CHANNEL_BITS-1:0] rsp_brightness
);
   import r2h_pkg::*;

   localparam int CB = CHANNEL_BITS;
   localparam int DIV_BITS = (CB > HUE_Q_BITS) ? CB : HUE_Q_BITS;
   localparam int RW = CB + DIV_BITS;

   // One record per divider stage.
   typedef struct packed {
      logic [RW-1:0]       rem_sat;
      logic [RW-1:0]       rem_hue;
      logic [DIV_BITS-1:0] q_sat;
      logic [DIV_BITS-1:0] q_hue;
      logic [CB-1:0]       mx;
      logic [CB-1:0]       diff;
      sector_type          sector;
      logic                neg;
   } div_rec_type;

   // The whole pipeline moves unless the output buffer is full.
   logic adv;

   // Input stage.
   logic          in_vld_ff, in_vld_in;
   logic [CB-1:0] in_r_ff, in_g_ff, in_b_ff;

   // Extremes stage.
   logic          pre_vld_ff, pre_vld_in;
   logic [CB-1:0] pre_mx_ff, pre_mx_in;
   logic [CB-1:0] pre_diff_ff, pre_diff_in;
   logic [CB-1:0] pre_num_ff, pre_num_in;
   sector_type    pre_sector_ff, pre_sector_in;
   logic          pre_neg_ff, pre_neg_in;

   // Divider stages; entry 0 holds the products.
   logic [DIV_BITS:0] dv_vld_ff, dv_vld_in;
   div_rec_type       dv_ff [DIV_BITS+1];
   div_rec_type       dv_in [DIV_BITS+1];
   logic [RW-1:0]     sat_sh [DIV_BITS];
   logic [RW-1:0]     hue_sh [DIV_BITS];
   logic              sat_bit [DIV_BITS];
   logic              hue_bit [DIV_BITS];
   logic [2*CB-1:0]   sat_prod;
   logic [CB+HUE_Q_BITS-1:0] hue_prod;

   // Final result and output buffer.
   logic [HUE_BITS-1:0] fin_hue, hue_q;
   logic [CB-1:0]       fin_sat;
   logic                arrive, take;
   logic                out_vld_ff, out_vld_in;
   logic                skid_full_ff, skid_full_in;
   logic [HUE_BITS-1:0] out_hue_ff, out_hue_in, skid_hue_ff;
   logic [CB-1:0]       out_sat_ff, out_sat_in, skid_sat_ff;
   logic [CB-1:0]       out_bri_ff, out_bri_in, skid_bri_ff;

   assign adv = !skid_full_ff;
   assign req_stall = skid_full_ff;

   // Input capture.
   assign in_vld_in = adv ? req_valid : in_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         in_r_ff <= req_red;
         in_g_ff <= req_green;
         in_b_ff <= req_blue;
      end
   end

   // Largest and smallest channel, hue sector and the signed hue numerator.
   always_comb begin
      logic [CB-1:0] mn;
      logic [CB-1:0] a;
      logic [CB-1:0] b;
      pre_vld_in = adv ? in_vld_ff : pre_vld_ff;
      if (in_r_ff >= in_g_ff && in_r_ff >= in_b_ff) begin
         pre_mx_in = in_r_ff;
         pre_sector_in = SECT_RED;
         a = in_g_ff;
         b = in_b_ff;
      end else if (in_g_ff >= in_b_ff) begin
         pre_mx_in = in_g_ff;
         pre_sector_in = SECT_GREEN;
         a = in_b_ff;
         b = in_r_ff;
      end else begin
         pre_mx_in = in_b_ff;
         pre_sector_in = SECT_BLUE;
         a = in_r_ff;
         b = in_g_ff;
      end
      mn = (in_r_ff < in_g_ff) ? in_r_ff : in_g_ff;
      mn = (in_b_ff < mn) ? in_b_ff : mn;
      pre_diff_in = pre_mx_in - mn;
      pre_neg_in = a < b;
      pre_num_in = pre_neg_in ? (b - a) : (a - b);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pre_mx_ff <= pre_mx_in;
         pre_diff_ff <= pre_diff_in;
         pre_num_ff <= pre_num_in;
         pre_sector_ff <= pre_sector_in;
         pre_neg_ff <= pre_neg_in;
      end
   end

   // Dividends: full scale times the spread, and one sixth circle times the numerator.
   assign sat_prod = {CB{1'b1}} * pre_diff_ff;
   assign hue_prod = HUE_SIXTH * pre_num_ff;

   // Restoring division, one quotient bit per stage, most significant bit first.
   // The dividends stay below divisor times 2^DIV_BITS, so no wider quotient exists.
   always_comb begin
      dv_vld_in[0] = adv ? pre_vld_ff : dv_vld_ff[0];
      dv_in[0].rem_sat = RW'(sat_prod);
      dv_in[0].rem_hue = RW'(hue_prod);
      dv_in[0].q_sat = '0;
      dv_in[0].q_hue = '0;
      dv_in[0].mx = pre_mx_ff;
      dv_in[0].diff = pre_diff_ff;
      dv_in[0].sector = pre_sector_ff;
      dv_in[0].neg = pre_neg_ff;
      for (int j = 0; j < DIV_BITS; j++) begin
         sat_sh[j] = RW'(dv_ff[j].mx) << (DIV_BITS - 1 - j);
         hue_sh[j] = RW'(dv_ff[j].diff) << (DIV_BITS - 1 - j);
         sat_bit[j] = dv_ff[j].rem_sat >= sat_sh[j];
         hue_bit[j] = dv_ff[j].rem_hue >= hue_sh[j];
         dv_vld_in[j+1] = adv ? dv_vld_ff[j] : dv_vld_ff[j+1];
         dv_in[j+1] = dv_ff[j];
         dv_in[j+1].rem_sat = sat_bit[j] ? (dv_ff[j].rem_sat - sat_sh[j])
                                         : dv_ff[j].rem_sat;
         dv_in[j+1].rem_hue = hue_bit[j] ? (dv_ff[j].rem_hue - hue_sh[j])
                                         : dv_ff[j].rem_hue;
         dv_in[j+1].q_sat = {dv_ff[j].q_sat[DIV_BITS-2:0], sat_bit[j]};
         dv_in[j+1].q_hue = {dv_ff[j].q_hue[DIV_BITS-2:0], hue_bit[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j <= DIV_BITS; j++) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // Hue from sector offset and signed quotient; grey and black pixels give zero.
   always_comb begin
      hue_q = HUE_BITS'(dv_ff[DIV_BITS].q_hue);
      case (dv_ff[DIV_BITS].sector)
         SECT_RED: begin
            fin_hue = (dv_ff[DIV_BITS].neg && hue_q != '0) ? (HUE_FULL - hue_q) : hue_q;
         end
         SECT_GREEN: begin
            fin_hue = dv_ff[DIV_BITS].neg ? (HUE_THIRD - hue_q) : (HUE_THIRD + hue_q);
         end
         SECT_BLUE: begin
            fin_hue = dv_ff[DIV_BITS].neg ? (HUE_TWO_THIRDS - hue_q)
                                          : (HUE_TWO_THIRDS + hue_q);
         end
         default: begin
            fin_hue = '0;
         end
      endcase
      if (dv_ff[DIV_BITS].diff == '0) begin
         fin_hue = '0;
      end
      fin_sat = (dv_ff[DIV_BITS].mx == '0) ? '0 : CB'(dv_ff[DIV_BITS].q_sat);
   end

   // Output register with one skid entry behind it.
   assign arrive = dv_vld_ff[DIV_BITS] && adv;
   assign take = out_vld_ff && !rsp_stall;

   always_comb begin
      out_vld_in = out_vld_ff;
      skid_full_in = skid_full_ff;
      out_hue_in = out_hue_ff;
      out_sat_in = out_sat_ff;
      out_bri_in = out_bri_ff;
      if (skid_full_ff) begin
         if (take) begin
            skid_full_in = 1'b0;
            out_hue_in = skid_hue_ff;
            out_sat_in = skid_sat_ff;
            out_bri_in = skid_bri_ff;
         end
      end else if (arrive) begin
         if (!out_vld_ff || take) begin
            out_vld_in = 1'b1;
            out_hue_in = fin_hue;
            out_sat_in = fin_sat;
            out_bri_in = dv_ff[DIV_BITS].mx;
         end else begin
            skid_full_in = 1'b1;
         end
      end else if (take) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_hue_ff <= out_hue_in;
      out_sat_ff <= out_sat_in;
      out_bri_ff <= out_bri_in;
      if (arrive && !skid_full_ff) begin
         skid_hue_ff <= fin_hue;
         skid_sat_ff <= fin_sat;
         skid_bri_ff <= dv_ff[DIV_BITS].mx;
      end
   end

   // Control state: valid bits and buffer occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         pre_vld_ff <= 1'b0;
         dv_vld_ff <= '0;
         out_vld_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         pre_vld_ff <= pre_vld_in;
         dv_vld_ff <= dv_vld_in;
         out_vld_ff <= out_vld_in;
         skid_full_ff <= skid_full_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_hue = out_hue_ff;
   assign rsp_saturation = out_sat_ff;
   assign rsp_brightness = out_bri_ff;

`ifndef SYNTHESIS
   // The skid entry is only ever used behind a held output beat.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_vld_ff)
      else $error("skid entry full while output register is empty");

   // The skid entry fills only when the output beat was held back.
   a_skid_fill_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_full_ff) |-> $past(rsp_stall))
      else $error("skid entry filled without a stalled output");

   // Hue stays inside one full circle.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_hue < HUE_FULL)
      else $error("hue out of range");

   // A black pixel has neither saturation nor hue.
   a_black_pixel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brightness == '0) |-> (rsp_saturation == '0 && rsp_hue == '0))
      else $error("black pixel with nonzero saturation or hue");
`endif

endmodule

// ----- test/rgb_to_hsv_pixel_convert_core_tb.sv -----
// Self-checking testbench for the RGB to HSV pixel converter with random handshake pressure.
module rgb_to_hsv_pixel_convert_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import r2h_pkg::*;

   // One converted pixel as it leaves the block.
   typedef struct packed {
      logic [HUE_BITS-1:0] hue;
      logic [7:0]          saturation;
      logic [7:0]          brightness;
   } hsv_beat_type;

   // One row of the directed stimulus; known is set where the result is typed in.
   typedef struct packed {
      logic         known;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      hsv_beat_type hsv;
   } pixel_row_type;

   localparam int NUM_DIRECTED = 24;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 30;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [7:0]          req_red;
   logic [7:0]          req_green;
   logic [7:0]          req_blue;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [HUE_BITS-1:0] rsp_hue;
   logic [7:0]          rsp_saturation;
   logic [7:0]          rsp_brightness;

   hsv_beat_type expected_hsv[$];
   int           mismatch_count = 0;
   bit           send_gaps_on = 1'b1;
   bit           recv_bursts_on = 1'b1;
   bit           long_hold_req = 1'b0;

   // Extremes, primaries, secondaries, ties and greys; the rest go to the predictor.
   pixel_row_type directed_rows [0:NUM_DIRECTED-1] = '{
      '{1'b1, 8'd0,   8'd0,   8'd0,   '{15'd0,     8'd0,   8'd0}},
      '{1'b1, 8'd255, 8'd255, 8'd255, '{15'd0,     8'd0,   8'd255}},
      '{1'b1, 8'd128, 8'd128, 8'd128, '{15'd0,     8'd0,   8'd128}},
      '{1'b1, 8'd1,   8'd1,   8'd1,   '{15'd0,     8'd0,   8'd1}},
      '{1'b1, 8'd255, 8'd0,   8'd0,   '{15'd0,     8'd255, 8'd255}},
      '{1'b1, 8'd0,   8'd255, 8'd0,   '{15'd7680,  8'd255, 8'd255}},
      '{1'b1, 8'd0,   8'd0,   8'd255, '{15'd15360, 8'd255, 8'd255}},
      '{1'b1, 8'd255, 8'd255, 8'd0,   '{15'd3840,  8'd255, 8'd255}},
      '{1'b1, 8'd0,   8'd255, 8'd255, '{15'd11520, 8'd255, 8'd255}},
      '{1'b1, 8'd255, 8'd0,   8'd255, '{15'd19200, 8'd255, 8'd255}},
      '{1'b0, 8'd255, 8'd0,   8'd1,   '0},
      '{1'b0, 8'd1,   8'd0,   8'd0,   '0},
      '{1'b0, 8'd0,   8'd1,   8'd0,   '0},
      '{1'b0, 8'd0,   8'd0,   8'd1,   '0},
      '{1'b0, 8'd255, 8'd254, 8'd253, '0},
      '{1'b0, 8'd254, 8'd255, 8'd255, '0},
      '{1'b0, 8'd128, 8'd255, 8'd0,   '0},
      '{1'b0, 8'd0,   8'd128, 8'd255, '0},
      '{1'b0, 8'd255, 8'd128, 8'd128, '0},
      '{1'b0, 8'd1,   8'd255, 8'd254, '0},
      '{1'b0, 8'd200, 8'd100, 8'd50,  '0},
      '{1'b0, 8'd50,  8'd200, 8'd100, '0},
      '{1'b0, 8'd100, 8'd50,  8'd200, '0},
      '{1'b0, 8'd127, 8'd128, 8'd128, '0}
   };

   rgb_to_hsv_pixel_convert_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   always #10 clock = ~clock;

   // Expected HSV of one pixel: value is the top channel, hue is split by the top channel.
   function automatic hsv_beat_type compute_hsv(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
      int red_i;
      int green_i;
      int blue_i;
      int top;
      int bottom;
      int spread;
      int delta;
      int offset;
      int hue_i;
      hsv_beat_type beat;
      red_i = r;
      green_i = g;
      blue_i = b;
      top = (red_i > green_i) ? red_i : green_i;
      top = (top > blue_i) ? top : blue_i;
      bottom = (red_i < green_i) ? red_i : green_i;
      bottom = (bottom < blue_i) ? bottom : blue_i;
      spread = top - bottom;
      beat.brightness = top[7:0];
      beat.saturation = (top == 0) ? 8'd0 : 8'((255 * spread) / top);
      hue_i = 0;
      // Ties on the top channel go to red first, then green.
      if (spread != 0) begin
         if (red_i == top) begin
            delta = green_i - blue_i;
            offset = 0;
         end else if (green_i == top) begin
            delta = blue_i - red_i;
            offset = int'(HUE_THIRD);
         end else begin
            delta = red_i - green_i;
            offset = int'(HUE_TWO_THIRDS);
         end
         // Signed division truncates toward zero; negative hues wrap once around the circle.
         hue_i = offset + (int'(HUE_SIXTH) * delta) / spread;
         if (hue_i < 0) begin
            hue_i = hue_i + int'(HUE_FULL);
         end
      end
      beat.hue = hue_i[HUE_BITS-1:0];
      return beat;
   endfunction

   // Offers one pixel, optionally after an idle burst, and holds it until accepted.
   task automatic offer_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input logic known, input hsv_beat_type known_hsv);
      @(negedge clock);
      if (send_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      forever begin
         @(posedge clock);
         if (!req_stall) begin
            break;
         end
      end
      expected_hsv.push_back(known ? known_hsv : compute_hsv(r, g, b));
   endtask

   // Sends a batch of random pixels biased toward greys, ties and extreme codes.
   task automatic offer_random_pixels(input int count);
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      logic [7:0] corner [0:3];
      corner = '{8'd0, 8'd1, 8'd254, 8'd255};
      repeat (count) begin
         r = 8'($urandom);
         g = 8'($urandom);
         b = 8'($urandom);
         case ($urandom_range(0, 7))
            0: begin
               g = r;
               b = r;
            end
            1: begin
               case ($urandom_range(0, 2))
                  0: g = r;
                  1: b = r;
                  default: b = g;
               endcase
            end
            2: begin
               r = corner[$urandom_range(0, 3)];
               g = corner[$urandom_range(0, 3)];
               b = corner[$urandom_range(0, 3)];
            end
            default: ;
         endcase
         offer_pixel(r, g, b, 1'b0, '0);
      end
   endtask

   // Waits until every expected pixel has come back.
   task automatic wait_drained();
      while (expected_hsv.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stall bursts, plus one long hold on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end else if (hold_left == 0 && recv_bursts_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 13);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      hsv_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hsv.size() == 0) begin
            $error("unexpected result beat: hue %0d saturation %0d brightness %0d",
                   rsp_hue, rsp_saturation, rsp_brightness);
            mismatch_count = mismatch_count + 1;
         end else begin
            want = expected_hsv.pop_front();
            if (rsp_hue !== want.hue) begin
               $error("hue: expected %0d, actual %0d", want.hue, rsp_hue);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_saturation !== want.saturation) begin
               $error("saturation: expected %0d, actual %0d", want.saturation, rsp_saturation);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_brightness !== want.brightness) begin
               $error("brightness: expected %0d, actual %0d", want.brightness, rsp_brightness);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
   end

   // Main sequence: reset, directed table, random phases with pressure, then drain.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_red = '0;
      req_green = '0;
      req_blue = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         offer_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                     directed_rows[i].known, directed_rows[i].hsv);
      end

      offer_random_pixels(400);

      // Long receiver hold while pixels keep coming, so the pipeline backs up.
      send_gaps_on = 1'b0;
      long_hold_req = 1'b1;
      offer_random_pixels(60);

      // Sender pauses until every pixel has been returned.
      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      send_gaps_on = 1'b1;

      offer_random_pixels(700);

      // Last stretch at full rate on both sides.
      send_gaps_on = 1'b0;
      recv_bursts_on = 1'b0;
      offer_random_pixels(340);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS rgb_to_hsv_pixel_convert_core");
      end else begin
         $display("FAIL rgb_to_hsv_pixel_convert_core");
      end
      $finish;
   end

   // Hard limit on run time.
   initial begin
      #10ms;
      $display("FAIL rgb_to_hsv_pixel_convert_core");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/r2h_pkg.sv
rtl/rgb_to_hsv_pixel_convert_core.sv
test/rgb_to_hsv_pixel_convert_core_tb.sv
